>>> rtl/waveform_sample_generator_assert.svh
// assertion macros for the waveform sample generator
`ifndef WAVEFORM_SAMPLE_GENERATOR_ASSERT_SVH
`define WAVEFORM_SAMPLE_GENERATOR_ASSERT_SVH

// condition must hold at every edge outside reset
`define WSG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define WSG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/wsg_pkg.sv
// shared types, constants and the quarter-wave sine table
package wsg_pkg;

  // field widths
  localparam int COL_W      = 12;
  localparam int COLS_W     = 13;
  localparam int CYC_W      = 13;
  localparam int CYC_FRAC_W = 8;
  localparam int PHASE_W    = 16;
  localparam int GAIN_W     = 15;
  localparam int SAMPLE_W   = 16;
  localparam int DATA_W     = 16;
  localparam int INDEX_W    = 3;

  // limits on the column count and cycle count
  localparam int MAX_COLUMNS = 4096;
  localparam int MIN_CYCLES  = 64;
  localparam int ONE_Q15     = 32767;

  // reset values of the registers
  localparam logic [COLS_W-1:0] COLUMN_COUNT_RESET   = COLS_W'(256);
  localparam logic [CYC_W-1:0]  CYCLES_RESET         = CYC_W'(256);
  localparam logic [PHASE_W-1:0] PHASE_OFFSET_RESET  = '0;
  localparam logic [GAIN_W-1:0] AMPLITUDE_GAIN_RESET = GAIN_W'(32767);

  // phase divider: long division of column*cycles*2^8 by the column count
  localparam int REM_W           = COLS_W - 1;
  localparam int PROD_W          = COL_W + CYC_W;
  localparam int DVD_W           = PROD_W + CYC_FRAC_W;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = DVD_W / STEPS_PER_STAGE;

  // queues between the parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // sine table
  localparam int QUARTER_SINE_ENTRIES = 256;
  localparam int SINE_IDX_W           = $clog2(QUARTER_SINE_ENTRIES);
  localparam int SINE_ADDR_W          = $clog2(QUARTER_SINE_ENTRIES + 1);
  localparam int SINE_W               = 15;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [INDEX_W-1:0] {
    REG_WAVE_SHAPE       = 3'd0,
    REG_COLUMN_COUNT     = 3'd1,
    REG_CYCLES_IN_WINDOW = 3'd2,
    REG_PHASE_OFFSET     = 3'd3,
    REG_AMPLITUDE_GAIN   = 3'd4
  } wsg_reg_t;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAWTOOTH = 2'd3
  } wsg_shape_t;

  // effective configuration, count and cycles already limited
  typedef struct packed {
    wsg_shape_t         wave_shape;
    logic [COLS_W-1:0]  column_count;
    logic [CYC_W-1:0]   cycles_in_window;
    logic [PHASE_W-1:0] phase_offset;
    logic [GAIN_W-1:0]  amplitude_gain;
  } wsg_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wsg_qstat_t;

  typedef logic [SINE_W-1:0] sine_rom_t [QUARTER_SINE_ENTRIES + 1];

  typedef logic [63:0] series_div_t [6];
  localparam series_div_t SERIES_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // odd power series of sin(pi/2 * k/N) in Q30, rounded to Q15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        rr;
    logic signed [63:0] acc;
    for (int k = 0; k <= QUARTER_SINE_ENTRIES; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / QUARTER_SINE_ENTRIES;
      term = x;
      acc = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / SERIES_DIV[n-1];
        if ((n & 1) == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = '0;
      end
      rr = (64'(acc) * 64'(ONE_Q15) + (64'd1 << 29)) >> 30;
      rom[k] = (rr > 64'(ONE_Q15)) ? SINE_W'(ONE_Q15) : rr[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/wsg_queue.sv
// short word queue between pipeline parts
module wsg_queue
  import wsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output wsg_qstat_t        stat
);

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

>>> rtl/wsg_front.sv
// front part: accept a column, form its phase by a pipelined long division
module wsg_front
  import wsg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  wsg_cfg_t           cfg,
  input  logic               push,
  input  logic [COL_W-1:0]   column_index,
  output logic               full,
  input  logic               q_full,
  output logic               q_push,
  output logic [PHASE_W-1:0] q_phase
);

  logic [DIV_STAGES:0] vld;
  logic [DVD_W-1:0]    dvd [DIV_STAGES + 1];
  logic [REM_W-1:0]    rem [DIV_STAGES + 1];
  logic [PHASE_W-1:0]  quo [DIV_STAGES + 1];
  logic                en;
  logic [PROD_W-1:0]   prod;

  // whole pipe holds while the last word cannot leave
  assign en      = !vld[DIV_STAGES] || !q_full;
  assign full    = !en;
  assign q_push  = vld[DIV_STAGES] && !q_full;
  assign q_phase = quo[DIV_STAGES] + cfg.phase_offset;
  assign prod    = PROD_W'(column_index) * PROD_W'(cfg.cycles_in_window);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd[0] <= {prod, {CYC_FRAC_W{1'b0}}};
      rem[0] <= '0;
      quo[0] <= '0;
    end
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [DVD_W-1:0]   d_n;
    logic [REM_W-1:0]   r_n;
    logic [PHASE_W-1:0] q_n;
    logic [REM_W:0]     t;

    // restoring steps, one dividend bit each
    always_comb begin
      d_n = dvd[j-1];
      r_n = rem[j-1];
      q_n = quo[j-1];
      t   = '0;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        t   = {r_n, d_n[DVD_W-1]};
        d_n = {d_n[DVD_W-2:0], 1'b0};
        if (t >= cfg.column_count) begin
          r_n = REM_W'(t - cfg.column_count);
          q_n = {q_n[PHASE_W-2:0], 1'b1};
        end else begin
          r_n = t[REM_W-1:0];
          q_n = {q_n[PHASE_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd[j] <= d_n;
        rem[j] <= r_n;
        quo[j] <= q_n;
      end
    end
  end

endmodule

>>> rtl/wsg_back.sv
// back part: shape lookup and gain scaling
module wsg_back
  import wsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  wsg_cfg_t            cfg,
  input  wsg_qstat_t          in_stat,
  input  logic [PHASE_W-1:0]  in_phase,
  output logic                in_pop,
  input  logic                out_full,
  output logic                out_push,
  output logic [SAMPLE_W-1:0] out_sample
);

  localparam int QB = PHASE_W - 2;

  logic                       v1;
  logic                       v2;
  logic                       en;
  logic signed [SAMPLE_W-1:0] shape_n;
  logic signed [SAMPLE_W-1:0] shape_q;
  logic signed [31:0]         prod_q;
  logic [1:0]                 quad;
  logic [SINE_IDX_W-1:0]      idx;
  logic [SINE_ADDR_W-1:0]     addr;
  logic signed [SAMPLE_W-1:0] sine_v;
  logic signed [18:0]         four_f;
  logic signed [18:0]         tri_raw;
  logic signed [18:0]         saw_raw;

  function automatic logic signed [SAMPLE_W-1:0] clamp_q15(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return SAMPLE_W'(ONE_Q15);
    end else if (v < -19'sd32767) begin
      return -SAMPLE_W'(ONE_Q15);
    end
    return v[SAMPLE_W-1:0];
  endfunction

  assign en         = !v2 || !out_full;
  assign in_pop     = en && !in_stat.empty;
  assign out_push   = v2 && !out_full;
  assign out_sample = prod_q[30:15];

  assign quad   = in_phase[PHASE_W-1 -: 2];
  assign idx    = in_phase[QB-1 -: SINE_IDX_W];
  // odd quadrants run the table backward
  assign addr   = quad[0] ? SINE_ADDR_W'(QUARTER_SINE_ENTRIES) - SINE_ADDR_W'(idx)
                          : SINE_ADDR_W'(idx);
  assign sine_v = quad[1] ? -$signed({1'b0, SINE_ROM[addr]})
                          : $signed({1'b0, SINE_ROM[addr]});
  assign four_f  = $signed({2'b00, in_phase, 1'b0});
  assign saw_raw = $signed({3'b000, in_phase}) - 19'sd32768;

  always_comb begin
    case (quad)
      2'd0:    tri_raw = four_f;
      2'd3:    tri_raw = four_f - 19'sd131072;
      default: tri_raw = 19'sd65536 - four_f;
    endcase
  end

  always_comb begin
    unique case (cfg.wave_shape)
      SHAPE_SINE:     shape_n = sine_v;
      SHAPE_SQUARE:   shape_n = quad[1] ? -SAMPLE_W'(ONE_Q15) : SAMPLE_W'(ONE_Q15);
      SHAPE_TRIANGLE: shape_n = clamp_q15(tri_raw);
      SHAPE_SAWTOOTH: shape_n = clamp_q15(saw_raw);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= !in_stat.empty;
      v2 <= v1;
    end
  end

  // product shifted right 15 floors toward minus infinity
  always_ff @(posedge clk) begin
    if (en) begin
      shape_q <= shape_n;
      prod_q  <= 32'(shape_q) * $signed({17'd0, cfg.amplitude_gain});
    end
  end

endmodule

>>> rtl/waveform_sample_generator.sv
// top level: registers, phase front, shape back and the queues between them
// path: divider pipe, middle queue, back shape and product registers, output queue
// one column word per cycle while full is low; divider pipe: 1 + 11 stages of 3 steps
// a stalled result side fills the output queue, then the middle queue, then raises full
// reset (rst, synchronous): queues emptied, pipes invalid, registers to their reset values
// the sine table is a constant and needs no fill after reset
module waveform_sample_generator
  import wsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                write_enable,
  input  logic [INDEX_W-1:0]  write_index,
  input  logic [DATA_W-1:0]   write_data,
  // column words in
  input  logic                push,
  output logic                full,
  input  logic [COL_W-1:0]    column_index,
  // sample words out
  output logic                empty,
  input  logic                pop,
  output logic [SAMPLE_W-1:0] sample_value
);

  `include "waveform_sample_generator_assert.svh"

  // raw registers as written
  wsg_shape_t         wave_shape;
  logic [COLS_W-1:0]  column_count;
  logic [CYC_W-1:0]   cycles_in_window;
  logic [PHASE_W-1:0] phase_offset;
  logic [GAIN_W-1:0]  amplitude_gain;

  wsg_cfg_t           cfg;
  logic               mq_push;
  logic [PHASE_W-1:0] mq_phase_in;
  logic [PHASE_W-1:0] mq_phase_out;
  logic               mq_pop;
  wsg_qstat_t         mq_stat;
  logic               oq_push;
  logic [SAMPLE_W-1:0] oq_data_in;
  wsg_qstat_t         oq_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape       <= SHAPE_SINE;
      column_count     <= COLUMN_COUNT_RESET;
      cycles_in_window <= CYCLES_RESET;
      phase_offset     <= PHASE_OFFSET_RESET;
      amplitude_gain   <= AMPLITUDE_GAIN_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_WAVE_SHAPE:       wave_shape       <= wsg_shape_t'(write_data[1:0]);
        REG_COLUMN_COUNT:     column_count     <= write_data[COLS_W-1:0];
        REG_CYCLES_IN_WINDOW: cycles_in_window <= write_data[CYC_W-1:0];
        REG_PHASE_OFFSET:     phase_offset     <= write_data[PHASE_W-1:0];
        REG_AMPLITUDE_GAIN:   amplitude_gain   <= write_data[GAIN_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // zero columns act as one, too many saturate, too few cycles rise to MIN_CYCLES
  always_comb begin
    cfg.wave_shape     = wave_shape;
    cfg.phase_offset   = phase_offset;
    cfg.amplitude_gain = amplitude_gain;
    if (column_count == '0) begin
      cfg.column_count = COLS_W'(1);
    end else if (column_count > COLS_W'(MAX_COLUMNS)) begin
      cfg.column_count = COLS_W'(MAX_COLUMNS);
    end else begin
      cfg.column_count = column_count;
    end
    if (cycles_in_window < CYC_W'(MIN_CYCLES)) begin
      cfg.cycles_in_window = CYC_W'(MIN_CYCLES);
    end else begin
      cfg.cycles_in_window = cycles_in_window;
    end
  end

  // column -> phase
  wsg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .column_index (column_index),
    .full         (full),
    .q_full       (mq_stat.full),
    .q_push       (mq_push),
    .q_phase      (mq_phase_in)
  );

  // phase words waiting for the back part
  wsg_queue u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (mq_push),
    .push_data (mq_phase_in),
    .pop       (mq_pop),
    .pop_data  (mq_phase_out),
    .stat      (mq_stat)
  );

  // phase -> scaled sample
  wsg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_stat    (mq_stat),
    .in_phase   (mq_phase_out),
    .in_pop     (mq_pop),
    .out_full   (oq_stat.full),
    .out_push   (oq_push),
    .out_sample (oq_data_in)
  );

  // result words, oldest on the ports
  wsg_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (oq_push),
    .push_data (oq_data_in),
    .pop       (pop),
    .pop_data  (sample_value),
    .stat      (oq_stat)
  );

  assign empty = oq_stat.empty;

  // the front only pushes into a middle queue with room
  `WSG_ASSERT_IMPLY(a_mid_no_overflow, mq_push, !mq_stat.full, "middle queue overflow")
  // the back only pushes into an output queue with room
  `WSG_ASSERT_IMPLY(a_out_no_overflow, oq_push, !oq_stat.full, "output queue overflow")
  // clamping keeps every sample inside plus or minus one
  `WSG_ASSERT_IMPLY(a_sample_range, !empty, sample_value != 16'h8000, "sample out of range")

endmodule
